@@ rtl/mfg_pkg.sv @@
package mfg_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int WREG_W      = 11;
  localparam int HREG_W      = 16;
  localparam int WX_W        = (WREG_W > COL_W + 1) ? WREG_W : COL_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WIN_N       = 9;
  localparam int NRES        = 4;
  localparam int JOBQ_DEPTH  = 4;
  localparam int JQP_W       = $clog2(JOBQ_DEPTH);
  localparam int JQC_W       = JQP_W + 1;
  localparam int OUTQ_DEPTH  = 4;
  localparam int OQP_W       = $clog2(OUTQ_DEPTH);
  localparam int OQC_W       = OQP_W + 1;
  localparam int RANK_W      = $clog2(WIN_N + 1);

  localparam logic [WREG_W-1:0] RESET_WIDTH  = WREG_W'(1024);
  localparam logic [HREG_W-1:0] RESET_HEIGHT = HREG_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic              vld;
    logic [WIN_N-1:0]  mask;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } res_t;

  typedef struct packed {
    sample_t [WIN_N-1:0] win;
    res_t    [NRES-1:0]  res;
  } job_t;

  typedef struct packed {
    sample_t          median;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } out_t;

  // window index is row*3+col, row 0 oldest, col 0 leftmost
  function automatic logic [WIN_N-1:0] win_mask(input logic incl_row0, input logic incl_col0);
    logic [WIN_N-1:0] m;
    for (int k = 0; k < WIN_N; k++) begin
      m[k] = ((k / 3) != 0 || incl_row0) && ((k % 3) != 0 || incl_col0);
    end
    return m;
  endfunction

endpackage

@@ rtl/median_filter_3x3_grid.sv @@
// 3x3 median filter over a raster-order grid stream, cropped at the borders.
// Input: push samples while full is low, row 0 left to right, then row 1, ...
// Output: a queue; while empty is low the oldest result sits on the ports,
// pop takes it. Each result carries its column, row and run_last, which marks
// the final result caused by one input sample.
// Configuration: cfg_valid_i/cfg_ready_o write grid_width (index 0) or
// grid_height (index 1) from cfg_data_i; a write restarts the frame. Write
// only while the block is idle. cfg_ready_o is always high.
// Throughput: one sample per cycle while full is low. Results leave one per
// cycle through the median pipeline while the output queue has room, so the
// up to four results of a row or frame end are absorbed by the four-entry job
// queue between front and back end. A result is poppable once its sample has
// passed the line store read, job queue, compare stage and output queue.
// When the result side stalls, the output queue fills, the back end stops
// issuing, the job queue fills and full rises; nothing is dropped.
// Reset clears the counters, the window and the queues and loads 1024 x 1024;
// the line stores are not cleared, unwritten rows are cropped away.
module median_filter_3x3_grid (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  mfg_pkg::sample_t                sample_i,
  output logic                            empty,
  input  logic                            pop,
  output mfg_pkg::sample_t                median_value_o,
  output logic [mfg_pkg::COL_W-1:0]       out_column_o,
  output logic [mfg_pkg::ROW_W-1:0]       out_row_o,
  output logic                            run_last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mfg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mfg_pkg::*;

  job_t             job, head;
  logic             job_push, job_pop, jq_empty;
  logic [JQC_W-1:0] jq_cnt;

  mfg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .jobq_cnt_i  (jq_cnt),
    .job_push_o  (job_push),
    .job_o       (job)
  );

  mfg_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .pop_i   (job_pop),
    .head_o  (head),
    .empty_o (jq_empty),
    .cnt_o   (jq_cnt)
  );

  mfg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .jobq_empty_i   (jq_empty),
    .job_pop_o      (job_pop),
    .pop            (pop),
    .empty          (empty),
    .median_value_o (median_value_o),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .run_last_o     (run_last_o)
  );

endmodule

@@ rtl/mfg_ram.sv @@
module mfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/mfg_front.sv @@
module mfg_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  mfg_pkg::sample_t                sample_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mfg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [mfg_pkg::JQC_W-1:0]       jobq_cnt_i,
  output logic                            job_push_o,
  output mfg_pkg::job_t                   job_o
);
  import mfg_pkg::*;

  logic [WREG_W-1:0] wreg_q;
  logic [HREG_W-1:0] hreg_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              b_valid_q;
  sample_t           b_s_q;
  logic [COL_W-1:0]  b_c_q;
  logic [ROW_W-1:0]  b_r_q;
  sample_t           win_q [WIN_N];
  sample_t           nw    [WIN_N];
  sample_t           older_rd, newer_rd;
  logic [WX_W-1:0]   wx;
  logic [COL_W:0]    weff;
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic              accept, cfg_wr;
  logic              r1, r2, c1, c2, cl, rl;
  logic [NRES-1:0]   vld;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign full        = ({1'b0, jobq_cnt_i} + (JQC_W + 1)'(b_valid_q)) >= (JQC_W + 1)'(JOBQ_DEPTH);
  assign accept      = push && !full;

  // clamp the width to between 2 and the line store depth
  assign wx = WX_W'(wreg_q);
  always_comb begin
    if (wreg_q < WREG_W'(2)) begin
      weff = (COL_W + 1)'(2);
    end else if (wx > WX_W'(MAX_WIDTH)) begin
      weff = (COL_W + 1)'(MAX_WIDTH);
    end else begin
      weff = (COL_W + 1)'(wx);
    end
  end
  assign wm1 = COL_W'(weff - (COL_W + 1)'(1));
  assign hm1 = (hreg_q < HREG_W'(2)) ? ROW_W'(1) : ROW_W'(hreg_q - HREG_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q    <= RESET_WIDTH;
      hreg_q    <= RESET_HEIGHT;
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (cfg_wr) begin
        unique case (cfg_index_i)
          CFG_GRID_WIDTH: begin
            wreg_q <= cfg_data_i[WREG_W-1:0];
            col_q  <= '0;
            row_q  <= '0;
          end
          CFG_GRID_HEIGHT: begin
            hreg_q <= cfg_data_i[HREG_W-1:0];
            col_q  <= '0;
            row_q  <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        if (col_q == wm1) begin
          col_q <= '0;
          row_q <= (row_q == hm1) ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_s_q <= sample_i;
      b_c_q <= col_q;
      b_r_q <= row_q;
    end
  end

  mfg_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_c_q),
    .wdata_i (newer_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (older_rd)
  );

  mfg_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_c_q),
    .wdata_i (b_s_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (newer_rd)
  );

  // shift the window left, new column on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nw[k*3]   = win_q[k*3+1];
      nw[k*3+1] = win_q[k*3+2];
    end
    nw[2] = older_rd;
    nw[5] = newer_rd;
    nw[8] = b_s_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_N; k++) win_q[k] <= '0;
    end else if (b_valid_q) begin
      for (int k = 0; k < WIN_N; k++) win_q[k] <= nw[k];
    end
  end

  assign r1 = b_r_q != '0;
  assign r2 = b_r_q >= ROW_W'(2);
  assign c1 = b_c_q != '0;
  assign c2 = b_c_q >= COL_W'(2);
  assign cl = b_c_q == wm1;
  assign rl = b_r_q == hm1;

  assign vld[0] = r1 && c1;
  assign vld[1] = r1 && cl;
  assign vld[2] = r1 && rl && c1;
  assign vld[3] = r1 && rl && cl;

  always_comb begin
    for (int k = 0; k < WIN_N; k++) job_o.win[k] = nw[k];
    job_o.res[0] = '{vld: vld[0], mask: win_mask(r2, c2), col: b_c_q - COL_W'(1),
                     row: b_r_q - ROW_W'(1), last: vld[0] && !(|vld[3:1])};
    job_o.res[1] = '{vld: vld[1], mask: win_mask(r2, 1'b0), col: wm1,
                     row: b_r_q - ROW_W'(1), last: vld[1] && !(|vld[3:2])};
    job_o.res[2] = '{vld: vld[2], mask: win_mask(1'b0, c2), col: b_c_q - COL_W'(1),
                     row: b_r_q, last: vld[2] && !vld[3]};
    job_o.res[3] = '{vld: vld[3], mask: win_mask(1'b0, 1'b0), col: wm1,
                     row: b_r_q, last: vld[3]};
  end

  // steps with no result leave nothing for the back end
  assign job_push_o = b_valid_q && (|vld);

endmodule

@@ rtl/mfg_jobq.sv @@
module mfg_jobq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  mfg_pkg::job_t             job_i,
  input  logic                      pop_i,
  output mfg_pkg::job_t             head_o,
  output logic                      empty_o,
  output logic [mfg_pkg::JQC_W-1:0] cnt_o
);
  import mfg_pkg::*;

  job_t             mem_q [JOBQ_DEPTH];
  logic [JQP_W-1:0] wp_q, rp_q;
  logic [JQC_W-1:0] cnt_q;

  assign head_o  = mem_q[rp_q];
  assign empty_o = cnt_q == '0;
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + JQP_W'(1);
      if (pop_i)  rp_q <= rp_q + JQP_W'(1);
      cnt_q <= cnt_q + JQC_W'(push_i) - JQC_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

endmodule

@@ rtl/mfg_back.sv @@
module mfg_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfg_pkg::job_t                head_i,
  input  logic                         jobq_empty_i,
  output logic                         job_pop_o,
  input  logic                         pop,
  output logic                         empty,
  output mfg_pkg::sample_t             median_value_o,
  output logic [mfg_pkg::COL_W-1:0]    out_column_o,
  output logic [mfg_pkg::ROW_W-1:0]    out_row_o,
  output logic                         run_last_o
);
  import mfg_pkg::*;

  logic [NRES-1:0]     done_q, pending, pick_oh, rest;
  logic [1:0]          pick;
  logic                room, issue;
  logic                s1v_q;
  sample_t             s1_win_q [WIN_N];
  logic [WIN_N-1:0]    s1_bf_q  [WIN_N];
  logic [WIN_N-1:0]    bf       [WIN_N];
  res_t                s1_res_q, cur;
  logic [RANK_W-1:0]   n, kth;
  logic [RANK_W-1:0]   rank [WIN_N];
  sample_t             med;
  out_t                oq_q [OUTQ_DEPTH];
  out_t                ohead;
  logic [OQP_W-1:0]    owp_q, orp_q;
  logic [OQC_W-1:0]    ocnt_q;
  logic                opop;

  always_comb begin
    for (int k = 0; k < NRES; k++) pending[k] = head_i.res[k].vld && !done_q[k];
    pick = '0;
    for (int k = NRES - 1; k >= 0; k--) begin
      if (pending[k]) pick = 2'(k);
    end
    pick_oh = NRES'(1) << pick;
    rest    = pending & ~pick_oh;
  end

  assign cur       = head_i.res[pick];
  assign room      = ({1'b0, ocnt_q} + (OQC_W + 1)'(s1v_q)) < (OQC_W + 1)'(OUTQ_DEPTH);
  assign issue     = !jobq_empty_i && room && (|pending);
  assign job_pop_o = issue && (rest == '0);

  // bf[i][j]: element j sorts ahead of element i, ties broken by index
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < WIN_N; j++) begin
        bf[i][j] = 1'b0;
      end
    end
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < i; j++) begin
        bf[i][j] = $signed(head_i.win[j]) <= $signed(head_i.win[i]);
        bf[j][i] = !(bf[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      s1v_q  <= 1'b0;
    end else begin
      s1v_q <= issue;
      if (job_pop_o) begin
        done_q <= '0;
      end else if (issue) begin
        done_q <= done_q | pick_oh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int k = 0; k < WIN_N; k++) begin
        s1_win_q[k] <= head_i.win[k];
        s1_bf_q[k]  <= bf[k];
      end
      s1_res_q <= cur;
    end
  end

  // rank each kept element, take the lower middle
  always_comb begin
    n = '0;
    for (int k = 0; k < WIN_N; k++) n = n + RANK_W'(s1_res_q.mask[k]);
    kth = (n - RANK_W'(1)) >> 1;
    med = '0;
    for (int i = 0; i < WIN_N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_N; j++) begin
        rank[i] = rank[i] + RANK_W'(s1_res_q.mask[j] && s1_bf_q[i][j]);
      end
      if (s1_res_q.mask[i] && rank[i] == kth) med = med | s1_win_q[i];
    end
  end

  assign opop  = pop && !empty;
  assign empty = ocnt_q == '0;
  assign ohead = oq_q[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (s1v_q) owp_q <= owp_q + OQP_W'(1);
      if (opop)  orp_q <= orp_q + OQP_W'(1);
      ocnt_q <= ocnt_q + OQC_W'(s1v_q) - OQC_W'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1v_q) begin
      oq_q[owp_q] <= '{median: med, col: s1_res_q.col, row: s1_res_q.row,
                       last: s1_res_q.last};
    end
  end

  assign median_value_o = ohead.median;
  assign out_column_o   = ohead.col;
  assign out_row_o      = ohead.row;
  assign run_last_o     = ohead.last;

endmodule

@@ tb/sv/tb_median_filter_3x3_grid.sv @@
module tb_median_filter_3x3_grid;
  import mfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam int IDLE_PCT    = 26;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 8;
  localparam int RANDOM_ITEMS = 160;

  typedef struct {
    sample_t          median;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } median_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  sample_t               sample_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  sample_t               median_value_o;
  logic [COL_W-1:0]      out_column_o;
  logic [ROW_W-1:0]      out_row_o;
  logic                  run_last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  median_filter_3x3_grid u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // grid model
  sample_t     old_line [MAX_WIDTH];
  sample_t     new_line [MAX_WIDTH];
  sample_t     win [WIN_N];
  int          col_cnt, row_cnt;
  logic [WREG_W-1:0] width_reg;
  logic [HREG_W-1:0] height_reg;

  sample_t     sample_fifo [$];
  median_rec_t median_fifo [$];
  int          errors = 0;
  int          cycle = 0;
  int          stall = 0;

  function automatic sample_t crop_median(int r0, int c0);
    sample_t v [WIN_N];
    sample_t k;
    int n, j;
    n = 0;
    for (int r = r0; r < 3; r++)
      for (int c = c0; c < 3; c++) begin
        v[n] = win[r * 3 + c];
        n++;
      end
    for (int i = 1; i < n; i++) begin
      k = v[i];
      j = i;
      while (j > 0 && v[j - 1] > k) begin
        v[j] = v[j - 1];
        j--;
      end
      v[j] = k;
    end
    return v[(n - 1) / 2];
  endfunction

  task automatic add_median(sample_t m, int c, int r);
    median_rec_t e;
    e.median = m;
    e.col = COL_W'(c);
    e.row = ROW_W'(r);
    e.last = 1'b0;
    median_fifo = {median_fifo, e};
  endtask

  task automatic add_sample(sample_t s);
    sample_fifo = {sample_fifo, s};
  endtask

  task automatic predict_sample(sample_t s);
    int w, h, c, r, top, left, n0;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg < 2) ? 2 : int'(height_reg);
    c = (col_cnt >= w) ? 0 : col_cnt;
    r = (row_cnt >= h) ? 0 : row_cnt;
    for (int k = 0; k < 3; k++) begin
      win[k * 3] = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = old_line[c];
    win[5] = new_line[c];
    win[8] = s;
    old_line[c] = new_line[c];
    new_line[c] = s;
    n0 = median_fifo.size();
    if (r >= 1) begin
      top = (r >= 2) ? 0 : 1;
      left = (c >= 2) ? 0 : 1;
      if (c >= 1) add_median(crop_median(top, left), c - 1, r - 1);
      if (c == w - 1) add_median(crop_median(top, 1), w - 1, r - 1);
      if (r == h - 1) begin
        if (c >= 1) add_median(crop_median(1, left), c - 1, r);
        if (c == w - 1) add_median(crop_median(1, 1), w - 1, r);
      end
    end
    if (median_fifo.size() > n0) median_fifo[median_fifo.size() - 1].last = 1'b1;
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  function automatic bit idle_now();
    if (cycle >= 250 && cycle < 500) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      old_line[i] = '0;
      new_line[i] = '0;
    end
    for (int i = 0; i < WIN_N; i++) win[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
  end

  // driver: pushes samples, model follows register writes and is updated on acceptance
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GRID_WIDTH) begin
          width_reg = cfg_data_i[WREG_W-1:0];
          col_cnt = 0;
          row_cnt = 0;
        end else if (cfg_index_i == CFG_GRID_HEIGHT) begin
          height_reg = cfg_data_i[HREG_W-1:0];
          col_cnt = 0;
          row_cnt = 0;
        end
      end
      if (push && !full) begin
        predict_sample(sample_i);
        void'(sample_fifo.pop_front());
      end
      if (sample_fifo.size() > 0 && !idle_now()) begin
        push <= 1'b1;
        sample_i <= sample_fifo[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (median_fifo.size() == 0) begin
          $display("%0t: unexpected item median=%0d col=%0d row=%0d last=%0b", $time,
                   median_value_o, out_column_o, out_row_o, run_last_o);
          errors++;
        end else begin
          if (median_value_o !== median_fifo[0].median) begin
            $display("%0t: median exp %0d got %0d", $time, median_fifo[0].median,
                     median_value_o);
            errors++;
          end
          if (out_column_o !== median_fifo[0].col) begin
            $display("%0t: column exp %0d got %0d", $time, median_fifo[0].col, out_column_o);
            errors++;
          end
          if (out_row_o !== median_fifo[0].row) begin
            $display("%0t: row exp %0d got %0d", $time, median_fifo[0].row, out_row_o);
            errors++;
          end
          if (run_last_o !== median_fifo[0].last) begin
            $display("%0t: run_last exp %0b got %0b", $time, median_fifo[0].last, run_last_o);
            errors++;
          end
          void'(median_fifo.pop_front());
        end
      end
      pop <= !idle_now();
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      stall <= 0;
    else
      stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0: return sample_t'(32'h8000_0000);
      1: return sample_t'(32'h7fff_ffff);
      2: return sample_t'($urandom_range(0, 6)) - 3;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (sample_fifo.size() != 0 || median_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic feed_random(int n);
    for (int i = 0; i < n; i++) add_sample(pick_sample());
    wait_drained();
  endtask

  initial begin
    int w, h, fed, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // smallest frame: four results on the final sample
    write_reg(CFG_GRID_WIDTH, 16'd2);
    write_reg(CFG_GRID_HEIGHT, 16'd2);
    add_sample(sample_t'(32'h8000_0000));
    add_sample(sample_t'(32'h7fff_ffff));
    add_sample(sample_t'(0));
    add_sample(sample_t'(-1));
    wait_drained();

    write_reg(CFG_GRID_WIDTH, 16'd3);
    write_reg(CFG_GRID_HEIGHT, 16'd3);
    add_sample(sample_t'(32'h7fff_ffff));
    add_sample(sample_t'(32'h8000_0000));
    add_sample(sample_t'(5));
    add_sample(sample_t'(5));
    add_sample(sample_t'(-5));
    add_sample(sample_t'(32'h8000_0000));
    add_sample(sample_t'(32'h7fff_ffff));
    add_sample(sample_t'(-1));
    add_sample(sample_t'(1));
    wait_drained();

    // out-of-range settings clamp to 2 x 2; spare indexes change nothing
    write_reg(CFG_GRID_WIDTH, 16'd0);
    write_reg(CFG_GRID_HEIGHT, 16'd1);
    write_reg(CFG_SPARE_LO, 16'hffff);
    feed_random(3);
    write_reg(CFG_SPARE_HI, 16'h5a5a);
    feed_random(5);

    // widest row, width clamps down to the line store size
    write_reg(CFG_GRID_WIDTH, 16'h07ff);
    write_reg(CFG_GRID_HEIGHT, 16'd2);
    feed_random(30);

    // upper data bits are dropped by the width register
    write_reg(CFG_GRID_WIDTH, 16'hf802);
    write_reg(CFG_GRID_HEIGHT, 16'hffff);
    feed_random(20);

    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      write_reg(CFG_GRID_WIDTH, 16'(w));
      write_reg(CFG_GRID_HEIGHT, 16'(h));
      // mostly whole frames, sometimes a cut-off one
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, w * h);
      end else begin
        n = w * h * $urandom_range(1, 2);
      end
      if (n > RANDOM_ITEMS - fed) n = RANDOM_ITEMS - fed;
      feed_random(n);
      fed += n;
    end

    wait_drained();
    if (errors == 0 && median_fifo.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
